// File: hdl/monomial_feature_expander_assert.svh
// Assertion macros shared by the monomial feature expander RTL.
// Included by modules that check their own sequencing; no other dependencies.
`ifndef MONOMIAL_FEATURE_EXPANDER_ASSERT_SVH
`define MONOMIAL_FEATURE_EXPANDER_ASSERT_SVH

// same-cycle implication
`define MFE_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication
`define MFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// File: hdl/mfe_pkg.sv
// Shared types, constants and helpers for the monomial feature expander.
// No dependencies; imported by every module of the block.
package mfe_pkg;

   localparam int MAX_VARS    = 4;
   localparam int MAX_DEG     = 3;
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC        = SAMPLE_BITS - 1;
   localparam int LVL_W       = $clog2(MAX_VARS);
   localparam int EXP_W       = $clog2(MAX_DEG + 1);
   localparam int CNT_W       = $clog2(MAX_VARS + 1);
   localparam int PROD_W      = 2 * SAMPLE_BITS;
   localparam int WIDE_W      = SAMPLE_BITS + 3;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   localparam sample_type QMAX = sample_type'((1 << FRAC) - 1);
   localparam sample_type QMIN = sample_type'(-(1 << FRAC));

   localparam logic [1:0] REG_NUM_VARS   = 2'd0;
   localparam logic [1:0] REG_MAX_DEGREE = 2'd1;
   localparam logic [1:0] REG_BASIS_MODE = 2'd2;

   typedef struct packed {
      logic load;
      logic cheb;
   } arith_ctrl_type;

   function automatic sample_type sat_wide(input logic signed [WIDE_W-1:0] v);
      if (v > WIDE_W'(QMAX)) begin
         return QMAX;
      end else if (v < WIDE_W'(QMIN)) begin
         return QMIN;
      end else begin
         return v[SAMPLE_BITS-1:0];
      end
   endfunction

endpackage

// File: hdl/mfe_arith.sv
// Shared multiply, round and saturate unit of the monomial feature expander.
// Depends on mfe_pkg.
module mfe_arith (
   input  logic                   clock,
   input  mfe_pkg::arith_ctrl_type ctrl,
   input  mfe_pkg::sample_type    x,
   input  mfe_pkg::sample_type    cur,
   input  mfe_pkg::sample_type    prev,
   output mfe_pkg::sample_type    nxt
);
   import mfe_pkg::*;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     cheb_ff, cheb_in;
   logic signed [PROD_W:0]   pow_rnd;
   logic signed [PROD_W:0]   cheb_rnd;
   logic signed [WIDE_W-1:0] pow_val;
   logic signed [WIDE_W-1:0] cheb_val;

   assign prod_in = ctrl.load ? PROD_W'(x * cur) : prod_ff;
   assign cheb_in = ctrl.load ? ctrl.cheb : cheb_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      cheb_ff <= cheb_in;
   end

   assign pow_rnd  = {prod_ff[PROD_W-1], prod_ff} + (PROD_W+1)'(1 << (FRAC - 1));
   assign cheb_rnd = {prod_ff[PROD_W-1], prod_ff} + (PROD_W+1)'(1 << (FRAC - 2));
   assign pow_val  = WIDE_W'($signed(pow_rnd[PROD_W:FRAC]));
   assign cheb_val = WIDE_W'(cheb_rnd[PROD_W:FRAC-1]) - WIDE_W'(prev);

   assign nxt = cheb_ff ? sat_wide(cheb_val) : sat_wide(pow_val);

endmodule

// File: hdl/monomial_feature_expander.sv
// Input takes one coordinate per transfer; up to 35 products a point. After the transfer
// that completes a point, the first product follows the descend and emit states and any
// result stall. Each innermost product takes the descend, emit, advance and update states
// on one shared multiplier, plus a state per level unwound or descended.
// Input is not ready while a burst runs. Reset (synchronous, active high) clears control
// state and sets num_vars 2, max_degree 2, basis_mode 0; stored coordinates are kept.
`include "monomial_feature_expander_assert.svh"
module monomial_feature_expander (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] coordinate
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] product
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mfe_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DESC = 5'b00010,
      ST_EMIT = 5'b00100,
      ST_ADV  = 5'b01000,
      ST_UPD  = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [2:0]            num_vars_ff, num_vars_in;
   logic [1:0]            max_degree_ff, max_degree_in;
   logic                  basis_mode_ff, basis_mode_in;
   logic [CNT_W-1:0]      load_cnt_ff, load_cnt_in;
   sample_type            coord_ff [MAX_VARS];
   sample_type            coord_in [MAX_VARS];
   sample_type            val_ff   [MAX_VARS];
   sample_type            val_in   [MAX_VARS];
   sample_type            prev_ff  [MAX_VARS];
   sample_type            prev_in  [MAX_VARS];
   logic [EXP_W-1:0]      exp_ff   [MAX_VARS];
   logic [EXP_W-1:0]      exp_in   [MAX_VARS];
   logic [EXP_W-1:0]      bud_ff   [MAX_VARS];
   logic [EXP_W-1:0]      bud_in   [MAX_VARS];
   logic [LVL_W-1:0]      lvl_ff, lvl_in;
   logic [LVL_W-1:0]      run_nvm1_ff, run_nvm1_in;
   logic                  run_cheb_ff, run_cheb_in;
   sample_type            rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [LVL_W-1:0]      nvm1;
   logic                  complete;
   logic                  all_done;
   logic                  out_free;
   logic [LVL_W-1:0]      lvl_up;
   logic [LVL_W-1:0]      lvl_down;
   logic                  csr_write;
   arith_ctrl_type        arith_ctrl;
   sample_type            arith_nxt;

   always_comb begin
      priority if (num_vars_ff == 3'd0) begin
         nvm1 = '0;
      end else if (num_vars_ff > 3'(MAX_VARS)) begin
         nvm1 = LVL_W'(MAX_VARS - 1);
      end else begin
         nvm1 = LVL_W'(num_vars_ff - 3'd1);
      end
   end

   assign complete  = load_cnt_ff >= CNT_W'(nvm1);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign lvl_up    = lvl_ff + LVL_W'(1);
   assign lvl_down  = lvl_ff - LVL_W'(1);
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      all_done = 1'b1;
      for (int i = 0; i < MAX_VARS; i++) begin
         if (LVL_W'(i) <= run_nvm1_ff && exp_ff[i] != bud_ff[i]) begin
            all_done = 1'b0;
         end
      end
   end

   assign arith_ctrl.load = (state_ff == ST_ADV) && (exp_ff[lvl_ff] < bud_ff[lvl_ff]);
   assign arith_ctrl.cheb = run_cheb_ff && (exp_ff[lvl_ff] != '0);

   mfe_arith u_arith (
      .clock (clock),
      .ctrl  (arith_ctrl),
      .x     (coord_ff[lvl_ff]),
      .cur   (val_ff[lvl_ff]),
      .prev  (prev_ff[lvl_ff]),
      .nxt   (arith_nxt)
   );

   always_comb begin
      state_in      = state_ff;
      num_vars_in   = num_vars_ff;
      max_degree_in = max_degree_ff;
      basis_mode_in = basis_mode_ff;
      load_cnt_in   = load_cnt_ff;
      coord_in      = coord_ff;
      val_in        = val_ff;
      prev_in       = prev_ff;
      exp_in        = exp_ff;
      bud_in        = bud_ff;
      lvl_in        = lvl_ff;
      run_nvm1_in   = run_nvm1_ff;
      run_cheb_in   = run_cheb_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_NUM_VARS:   num_vars_in   = csr_pwdata[2:0];
            REG_MAX_DEGREE: max_degree_in = csr_pwdata[1:0];
            REG_BASIS_MODE: basis_mode_in = csr_pwdata[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               coord_in[load_cnt_ff[LVL_W-1:0]] = req_tdata;
               if (complete) begin
                  load_cnt_in = '0;
                  lvl_in      = '0;
                  val_in[0]   = QMAX;
                  prev_in[0]  = '0;
                  exp_in[0]   = '0;
                  bud_in[0]   = EXP_W'(max_degree_ff);
                  run_nvm1_in = nvm1;
                  run_cheb_in = basis_mode_ff;
                  state_in    = ST_DESC;
               end else begin
                  load_cnt_in = load_cnt_ff + CNT_W'(1);
               end
            end
         end
         ST_DESC: begin
            if (lvl_ff < run_nvm1_ff) begin
               val_in[lvl_up]  = val_ff[lvl_ff];
               prev_in[lvl_up] = '0;
               exp_in[lvl_up]  = '0;
               bud_in[lvl_up]  = bud_ff[lvl_ff] - exp_ff[lvl_ff];
               lvl_in          = lvl_up;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_data_in  = val_ff[lvl_ff];
               rsp_last_in  = all_done;
               rsp_valid_in = 1'b1;
               state_in     = ST_ADV;
            end
         end
         ST_ADV: begin
            priority if (exp_ff[lvl_ff] < bud_ff[lvl_ff]) begin
               state_in = ST_UPD;
            end else if (lvl_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               lvl_in = lvl_down;
            end
         end
         ST_UPD: begin
            val_in[lvl_ff]  = arith_nxt;
            prev_in[lvl_ff] = val_ff[lvl_ff];
            exp_in[lvl_ff]  = exp_ff[lvl_ff] + EXP_W'(1);
            state_in        = ST_DESC;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         num_vars_ff   <= 3'd2;
         max_degree_ff <= 2'd2;
         basis_mode_ff <= 1'b0;
         load_cnt_ff   <= '0;
         lvl_ff        <= '0;
         run_nvm1_ff   <= '0;
         run_cheb_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         num_vars_ff   <= num_vars_in;
         max_degree_ff <= max_degree_in;
         basis_mode_ff <= basis_mode_in;
         load_cnt_ff   <= load_cnt_in;
         lvl_ff        <= lvl_in;
         run_nvm1_ff   <= run_nvm1_in;
         run_cheb_ff   <= run_cheb_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      coord_ff    <= coord_in;
      val_ff      <= val_in;
      prev_ff     <= prev_in;
      exp_ff      <= exp_in;
      bud_ff      <= bud_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_NUM_VARS:   csr_prdata = {29'd0, num_vars_ff};
         REG_MAX_DEGREE: csr_prdata = {30'd0, max_degree_ff};
         REG_BASIS_MODE: csr_prdata = {31'd0, basis_mode_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `MFE_ASSERT_IMPLIES(a_cnt_range, clock, reset, 1'b1, load_cnt_ff < CNT_W'(MAX_VARS))
   `MFE_ASSERT_IMPLIES(a_lvl_range, clock, reset, state_ff != ST_IDLE, lvl_ff <= run_nvm1_ff)
   `MFE_ASSERT_IMPLIES(a_exp_budget, clock, reset, state_ff != ST_IDLE, exp_ff[lvl_ff] <= bud_ff[lvl_ff])
   `MFE_ASSERT_NEXT(a_last_flag, clock, reset, state_ff == ST_EMIT && out_free && all_done, rsp_tvalid && rsp_tlast && state_ff == ST_ADV)

endmodule
